>>> hw/rtl/mp2a_pkg.sv
// Shared constants and types of the max pooling with argmax block.
// Depends on nothing; imported by the top level.
`default_nettype none

package mp2a_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int KCFG_W     = 4;
  localparam int STRIDE_W   = 4;

  // Flat in-plane index of a result.
  localparam int IDX_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_WIDTH  = 3'd5;

  localparam logic [CFG_DATA_W-1:0] RST_IN_DIM = 11'd32;
  localparam logic [KCFG_W-1:0]     RST_KERNEL = 4'd2;
  localparam logic [STRIDE_W-1:0]   RST_STRIDE = 4'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/max_pool_2d_argmax_core.sv
// Top level of the streaming 2-D max pooling unit with argmax.
// Depends on mp2a_pkg and mp2a_ram.
`default_nettype none

// Takes one plane element per word in raster order and returns, for every
// pooling window it completes, the window maximum and the flat in-plane index
// of that maximum (ties keep the earlier index). Running maxima live in one
// single-port accumulator RAM addressed by window row (mod the kernel bound)
// and window column. An accepted element is scanned over its candidate
// windows, and each window that it falls in needs a RAM read and then a
// write on the one port; the write that completes a window waits while the
// output register still holds an unread result. The next element is taken
// only once the scan of the last one has ended. A finished result waits in
// the output register while the next element is taken. A write to any of the
// six configuration registers restarts the plane; no clearing pass is needed.

module max_pool_2d_argmax_core #(
  parameter int MAX_DIM    = 1024,
  parameter int MAX_KERNEL = 8,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mp2a_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [mp2a_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic signed [DATA_WIDTH-1:0]     pixel_value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [DATA_WIDTH-1:0]          max_value_o,
  output logic [mp2a_pkg::IDX_W-1:0]            max_index_o,
  output logic                                  plane_done_o
);

  import mp2a_pkg::*;

  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int KS_W    = $clog2(MAX_KERNEL);
  localparam int KE_W    = $clog2(MAX_KERNEL + 1);
  localparam int SUM_W   = DIM_W + 2;
  localparam int ENTRY_W = DATA_WIDTH + IDX_W;
  localparam int ADDR_W  = KS_W + POS_W;
  localparam int DEPTH   = 2 ** ADDR_W;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] in_height_q, in_width_q;
  logic [KCFG_W-1:0]     kernel_height_q, kernel_width_q;
  logic [STRIDE_W-1:0]   stride_height_q, stride_width_q;
  logic                  cfg_hit;

  always_comb begin
    cfg_hit = cfg_we_i && (cfg_index_i == REG_IN_HEIGHT || cfg_index_i == REG_IN_WIDTH ||
              cfg_index_i == REG_KERNEL_HEIGHT || cfg_index_i == REG_KERNEL_WIDTH ||
              cfg_index_i == REG_STRIDE_HEIGHT || cfg_index_i == REG_STRIDE_WIDTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_height_q     <= RST_IN_DIM;
      in_width_q      <= RST_IN_DIM;
      kernel_height_q <= RST_KERNEL;
      kernel_width_q  <= RST_KERNEL;
      stride_height_q <= RST_STRIDE;
      stride_width_q  <= RST_STRIDE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IN_HEIGHT:     in_height_q     <= cfg_wdata_i;
        REG_IN_WIDTH:      in_width_q      <= cfg_wdata_i;
        REG_KERNEL_HEIGHT: kernel_height_q <= cfg_wdata_i[KCFG_W-1:0];
        REG_KERNEL_WIDTH:  kernel_width_q  <= cfg_wdata_i[KCFG_W-1:0];
        REG_STRIDE_HEIGHT: stride_height_q <= cfg_wdata_i[STRIDE_W-1:0];
        REG_STRIDE_WIDTH:  stride_width_q  <= cfg_wdata_i[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry after the zero and saturation rules.
  logic [DIM_W-1:0]    h_eff, w_eff;
  logic [KE_W-1:0]     kh_sat, kw_sat, kh_eff, kw_eff;
  logic [STRIDE_W-1:0] sh_eff, sw_eff;

  always_comb begin
    if (in_height_q == '0) h_eff = DIM_W'(1);
    else if (32'(in_height_q) > MAX_DIM) h_eff = DIM_W'(MAX_DIM);
    else h_eff = DIM_W'(in_height_q);
    if (in_width_q == '0) w_eff = DIM_W'(1);
    else if (32'(in_width_q) > MAX_DIM) w_eff = DIM_W'(MAX_DIM);
    else w_eff = DIM_W'(in_width_q);

    if (kernel_height_q == '0) kh_sat = KE_W'(1);
    else if (32'(kernel_height_q) > MAX_KERNEL) kh_sat = KE_W'(MAX_KERNEL);
    else kh_sat = KE_W'(kernel_height_q);
    if (kernel_width_q == '0) kw_sat = KE_W'(1);
    else if (32'(kernel_width_q) > MAX_KERNEL) kw_sat = KE_W'(MAX_KERNEL);
    else kw_sat = KE_W'(kernel_width_q);

    // A kernel larger than the plane shrinks to the plane.
    kh_eff = (SUM_W'(kh_sat) > SUM_W'(h_eff)) ? KE_W'(h_eff) : kh_sat;
    kw_eff = (SUM_W'(kw_sat) > SUM_W'(w_eff)) ? KE_W'(w_eff) : kw_sat;

    sh_eff = (stride_height_q == '0) ? STRIDE_W'(1) : stride_height_q;
    sw_eff = (stride_width_q == '0) ? STRIDE_W'(1) : stride_width_q;
  end

  // Position of the next element. The div/start/mod registers track the
  // last window that begins at or before the current row and column.
  logic [POS_W-1:0]    row_q, col_q, row_div_q, col_div_q, row_start_q, col_start_q;
  logic [STRIDE_W-1:0] row_mod_q, col_mod_q;
  logic [IDX_W-1:0]    row_base_q;
  logic                in_acc, last_col, last_row;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign last_col   = (SUM_W'(col_q) + SUM_W'(1)) >= SUM_W'(w_eff);
  assign last_row   = (SUM_W'(row_q) + SUM_W'(1)) >= SUM_W'(h_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0; col_q <= '0; row_div_q <= '0; col_div_q <= '0;
      row_start_q <= '0; col_start_q <= '0; row_mod_q <= '0; col_mod_q <= '0;
      row_base_q <= '0;
    end else if (cfg_hit) begin
      row_q <= '0; col_q <= '0; row_div_q <= '0; col_div_q <= '0;
      row_start_q <= '0; col_start_q <= '0; row_mod_q <= '0; col_mod_q <= '0;
      row_base_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0; col_div_q <= '0; col_start_q <= '0; col_mod_q <= '0;
        if (last_row) begin
          row_q <= '0; row_div_q <= '0; row_start_q <= '0; row_mod_q <= '0;
          row_base_q <= '0;
        end else begin
          row_q      <= row_q + POS_W'(1);
          row_base_q <= row_base_q + IDX_W'(w_eff);
          if (row_mod_q == sh_eff - STRIDE_W'(1)) begin
            row_mod_q   <= '0;
            row_div_q   <= row_div_q + POS_W'(1);
            row_start_q <= row_q + POS_W'(1);
          end else begin
            row_mod_q <= row_mod_q + STRIDE_W'(1);
          end
        end
      end else begin
        col_q <= col_q + POS_W'(1);
        if (col_mod_q == sw_eff - STRIDE_W'(1)) begin
          col_mod_q   <= '0;
          col_div_q   <= col_div_q + POS_W'(1);
          col_start_q <= col_q + POS_W'(1);
        end else begin
          col_mod_q <= col_mod_q + STRIDE_W'(1);
        end
      end
    end
  end

  // Per-element work registers.
  logic signed [DATA_WIDTH-1:0] val_q;
  logic [POS_W-1:0] r_q, c_q, cd_q, cs_q;
  logic [POS_W-1:0] ph_q, phs_q, pw_q, pws_q;
  logic [POS_W-1:0] ph_d, phs_d, pw_d, pws_d;
  logic [IDX_W-1:0] idx_q;

  // Candidate window evaluation.
  logic row_in, col_in, fits, first, complete, last_win, cand_done;
  logic signed [DATA_WIDTH-1:0] rd_max, new_max;
  logic [IDX_W-1:0]   rd_idx, new_idx;
  logic               take, stall;
  logic [ENTRY_W-1:0] rd_data;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_addr;

  always_comb begin
    row_in   = (SUM_W'(phs_q) + SUM_W'(kh_eff)) > SUM_W'(r_q);
    col_in   = (SUM_W'(pws_q) + SUM_W'(kw_eff)) > SUM_W'(c_q);
    fits     = ((SUM_W'(phs_q) + SUM_W'(kh_eff)) <= SUM_W'(h_eff)) &&
               ((SUM_W'(pws_q) + SUM_W'(kw_eff)) <= SUM_W'(w_eff));
    first    = (r_q == phs_q) && (c_q == pws_q);
    complete = ((SUM_W'(phs_q) + SUM_W'(kh_eff)) == (SUM_W'(r_q) + SUM_W'(1))) &&
               ((SUM_W'(pws_q) + SUM_W'(kw_eff)) == (SUM_W'(c_q) + SUM_W'(1)));
    // The last window of a plane is the one with no room for a next window.
    last_win = ((SUM_W'(phs_q) + SUM_W'(sh_eff) + SUM_W'(kh_eff)) > SUM_W'(h_eff)) &&
               ((SUM_W'(pws_q) + SUM_W'(sw_eff) + SUM_W'(kw_eff)) > SUM_W'(w_eff));

    rd_max  = rd_data[ENTRY_W-1:IDX_W];
    rd_idx  = rd_data[IDX_W-1:0];
    take    = first || (val_q > rd_max);
    new_max = take ? val_q : rd_max;
    new_idx = take ? idx_q : rd_idx;

    // Step to the next candidate: leftward along the window row, then up.
    ph_d = ph_q; phs_d = phs_q; pw_d = pw_q; pws_d = pws_q;
    cand_done = 1'b0;
    if (col_in && pw_q != '0) begin
      pw_d  = pw_q - POS_W'(1);
      pws_d = pws_q - POS_W'(sw_eff);
    end else begin
      pw_d  = cd_q;
      pws_d = cs_q;
      if (ph_q != '0) begin
        ph_d  = ph_q - POS_W'(1);
        phs_d = phs_q - POS_W'(sh_eff);
      end else begin
        cand_done = 1'b1;
      end
    end

    stall    = complete && out_valid_o && !out_ready_i;
    mem_addr = {ph_q[KS_W-1:0], pw_q};
    mem_re   = (state_q == ST_SCAN) && row_in && col_in && fits;
    mem_we   = (state_q == ST_UPD) && !stall;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SCAN;
      ST_SCAN: begin
        if (!row_in) state_d = ST_IDLE;
        else if (col_in && fits) state_d = ST_UPD;
        else if (cand_done) state_d = ST_IDLE;
      end
      ST_UPD: begin
        if (!stall) state_d = cand_done ? ST_IDLE : ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      val_q <= pixel_value_i;
      r_q   <= row_q;
      c_q   <= col_q;
      cd_q  <= col_div_q;
      cs_q  <= col_start_q;
      ph_q  <= row_div_q;
      phs_q <= row_start_q;
      pw_q  <= col_div_q;
      pws_q <= col_start_q;
      idx_q <= row_base_q + IDX_W'(col_q);
    end else if ((state_q == ST_SCAN && !(col_in && fits)) ||
                 (state_q == ST_UPD && !stall)) begin
      ph_q  <= ph_d;
      phs_q <= phs_d;
      pw_q  <= pw_d;
      pws_q <= pws_d;
    end
  end

  mp2a_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i ({new_max, new_idx}),
    .rdata_o (rd_data)
  );

  // Output register.
  logic out_load;
  assign out_load = (state_q == ST_UPD) && complete && !stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      max_value_o  <= new_max;
      max_index_o  <= new_idx;
      plane_done_o <= last_win;
    end
  end

  // Checks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_SCAN)
    else $error("accepted word did not start a scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_UPD))
    else $error("result appeared outside an accumulator update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> $past(state_q == ST_SCAN) || $past(state_q == ST_UPD))
    else $error("update without a preceding accumulator read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SUM_W'(col_q) < SUM_W'(w_eff)) && (SUM_W'(row_q) < SUM_W'(h_eff)))
    else $error("position left the plane");

endmodule

`default_nettype wire

>>> hw/rtl/mp2a_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
`default_nettype none

module mp2a_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire
